/* rtl/dxs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the descending exchange sorter.
// Has no dependencies; used by descending_exchange_sorter.

package dxs_pkg;

	localparam int DATA_W        = 32;
	localparam int DEPTH_DEFAULT = 64;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RD_I,
		ST_LD_I,
		ST_CMP,
		ST_WB_I,
		ST_E_RD,
		ST_E_WR
	} state_t;

endpackage

/* rtl/dxs_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.

module dxs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/descending_exchange_sorter.sv */
`timescale 1ns / 1ps
// Descending exchange sorter: collects a set of signed values and returns them largest first.
// Depends on dxs_pkg and dxs_ram.
//
// Usage:
// The input channel (in_valid/in_ready, value, is_last) takes one request per cycle while
// the block is loading. Each value is written to the element RAM; values beyond DEPTH are
// dropped. The request flagged is_last closes the set and starts the sort.
// The sort keeps the running element of position i in a register and streams the earlier
// positions out of the RAM through its single read port, writing back on each exchange.
// Each position is read, loaded into the register, compared against every earlier position
// and then written back; the input is not ready meanwhile.
// The sorted values then leave on the output channel (out_valid/out_ready, sorted_value,
// is_final), largest first, each read once the output register is free; is_final
// marks the smallest. When the receiver stalls, the output register holds its request and
// the RAM is not read until it is taken. Once the last result sits in the output register
// the block returns to loading and accepts a new set even while that result waits.
// Reset (arst_n low) empties the set and the output register; the RAM is not cleared,
// since only entries written for the current set are ever read.

module descending_exchange_sorter #(
	parameter int DEPTH = dxs_pkg::DEPTH_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [dxs_pkg::DATA_W-1:0]  value,
	input  logic                               is_last,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [dxs_pkg::DATA_W-1:0]  sorted_value,
	output logic                               is_final
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	dxs_pkg::state_t state_q, state_nx;

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nx;
	logic [CW-1:0] n_q;
	logic [AW-1:0] i_q, j_q, k_q;
	logic signed [dxs_pkg::DATA_W-1:0] cur_q;
	logic signed [dxs_pkg::DATA_W-1:0] out_data_q;
	logic out_valid_q, out_final_q;

	logic                       ram_we, ram_re;
	logic [AW-1:0]              ram_waddr, ram_raddr;
	logic [dxs_pkg::DATA_W-1:0] ram_wdata, ram_rdata;

	logic in_fire, room, gt, out_free;
	logic j_end, i_end, k_end;

	assign in_ready = (state_q == dxs_pkg::ST_LOAD);
	assign in_fire  = in_valid && in_ready;
	assign room     = (count_q < DEPTH_C);
	assign count_nx = room ? (count_q + CW'(1)) : count_q;
	assign gt       = (cur_q > $signed(ram_rdata));
	assign out_free = !out_valid_q || out_ready;
	assign j_end    = (AW'(j_q + AW'(1)) == i_q);
	assign i_end    = ((CW'(i_q) + CW'(1)) == n_q);
	assign k_end    = ((CW'(k_q) + CW'(1)) == n_q);

	dxs_ram #(
		.WIDTH(dxs_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			dxs_pkg::ST_LOAD: begin
				if (in_fire && is_last) begin
					state_nx = dxs_pkg::ST_RD_I;
				end
			end
			dxs_pkg::ST_RD_I: begin
				state_nx = dxs_pkg::ST_LD_I;
			end
			dxs_pkg::ST_LD_I: begin
				state_nx = (i_q == '0) ? dxs_pkg::ST_WB_I : dxs_pkg::ST_CMP;
			end
			dxs_pkg::ST_CMP: begin
				if (j_end) begin
					state_nx = dxs_pkg::ST_WB_I;
				end
			end
			dxs_pkg::ST_WB_I: begin
				state_nx = i_end ? dxs_pkg::ST_E_RD : dxs_pkg::ST_RD_I;
			end
			dxs_pkg::ST_E_RD: begin
				if (out_free) begin
					state_nx = dxs_pkg::ST_E_WR;
				end
			end
			dxs_pkg::ST_E_WR: begin
				state_nx = k_end ? dxs_pkg::ST_LOAD : dxs_pkg::ST_E_RD;
			end
			default: begin
				state_nx = dxs_pkg::ST_LOAD;
			end
		endcase
	end

	// The compare state reads the following position while it writes back the current one,
	// so the two ports never touch the same entry in one cycle.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = cur_q;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			dxs_pkg::ST_LOAD: begin
				ram_we    = in_fire && room;
				ram_waddr = count_q[AW-1:0];
				ram_wdata = value;
			end
			dxs_pkg::ST_RD_I: begin
				ram_re    = 1'b1;
				ram_raddr = i_q;
			end
			dxs_pkg::ST_LD_I: begin
				ram_re    = 1'b1;
				ram_raddr = '0;
			end
			dxs_pkg::ST_CMP: begin
				ram_we    = gt;
				ram_waddr = j_q;
				ram_re    = 1'b1;
				ram_raddr = AW'(j_q + AW'(1));
			end
			dxs_pkg::ST_WB_I: begin
				ram_we    = 1'b1;
				ram_waddr = i_q;
			end
			dxs_pkg::ST_E_RD: begin
				ram_re    = out_free;
				ram_raddr = k_q;
			end
			dxs_pkg::ST_E_WR: begin
				ram_re = 1'b0;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dxs_pkg::ST_LOAD;
			count_q     <= '0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				dxs_pkg::ST_LOAD: begin
					if (in_fire) begin
						if (is_last) begin
							n_q     <= count_nx;
							count_q <= '0;
							i_q     <= '0;
						end else begin
							count_q <= count_nx;
						end
					end
				end
				dxs_pkg::ST_LD_I: begin
					j_q <= '0;
				end
				dxs_pkg::ST_CMP: begin
					j_q <= AW'(j_q + AW'(1));
				end
				dxs_pkg::ST_WB_I: begin
					i_q <= AW'(i_q + AW'(1));
					k_q <= '0;
				end
				dxs_pkg::ST_E_WR: begin
					out_valid_q <= 1'b1;
					k_q         <= AW'(k_q + AW'(1));
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	// Datapath registers need no reset.
	always_ff @(posedge clk) begin
		if (state_q == dxs_pkg::ST_LD_I) begin
			cur_q <= $signed(ram_rdata);
		end else if (state_q == dxs_pkg::ST_CMP && gt) begin
			cur_q <= $signed(ram_rdata);
		end
		if (state_q == dxs_pkg::ST_E_WR) begin
			out_data_q  <= $signed(ram_rdata);
			out_final_q <= k_end;
		end
	end

	assign out_valid    = out_valid_q;
	assign sorted_value = out_data_q;
	assign is_final     = out_final_q;

endmodule
